>>> hdl/pfd_pkg.sv
package pfd_pkg;

    // Frame layout
    localparam int PAYLOAD_LEN = 24;
    localparam int WORD_COUNT  = 6;
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int IDX_W       = 5;

    // Framing bytes
    localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAYLOAD_LEN - 1);

    // Deframer phases, one-hot
    typedef enum logic [4:0] {
        PH_HUNT_CR    = 5'b00001,
        PH_HEAD_LF    = 5'b00010,
        PH_PAYLOAD    = 5'b00100,
        PH_TRAIL_LF   = 5'b01000,
        PH_TRAIL_CR   = 5'b10000
    } phase_t;

    // Controls from the sequencer to the cell row and the result register
    typedef struct packed {
        logic shift;
        logic done;
    } pfd_ctrl_t;

endpackage

>>> hdl/pfd_if.sv
interface pfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pfd_pose_if;
    logic        valid;
    logic        ready;
    logic [31:0] yaw_bits;
    logic [31:0] pitch_bits;
    logic [31:0] roll_bits;
    logic [31:0] pos_x_bits;
    logic [31:0] pos_y_bits;
    logic [31:0] yaw_rate_bits;

    modport source (
        output valid, output yaw_bits, output pitch_bits, output roll_bits,
        output pos_x_bits, output pos_y_bits, output yaw_rate_bits,
        input ready
    );
    modport sink (
        input valid, input yaw_bits, input pitch_bits, input roll_bits,
        input pos_x_bits, input pos_y_bits, input yaw_rate_bits,
        output ready
    );
endinterface

>>> hdl/pfd_byte_cell.sv
module pfd_byte_cell (
    input  logic                        clk,
    input  logic                        shift,
    input  logic [pfd_pkg::BYTE_W-1:0]  byte_in,
    output logic [pfd_pkg::BYTE_W-1:0]  byte_out
);
    import pfd_pkg::*;

    logic [BYTE_W-1:0] byte_reg;

    // Take the neighbor's byte on each payload transfer
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

endmodule

>>> hdl/pfd_ctrl.sv
module pfd_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [pfd_pkg::BYTE_W-1:0]  rx_byte,
    output pfd_pkg::pfd_ctrl_t          ctl,
    output logic                        at_trail_cr
);
    import pfd_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    // Header / payload / trailer sequencing
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_HUNT_CR:
                begin
                    phase_next = (rx_byte == BYTE_CR) ? PH_HEAD_LF : PH_HUNT_CR;
                end
                PH_HEAD_LF:
                begin
                    if (rx_byte == BYTE_LF)
                    begin
                        idx_next   = '0;
                        phase_next = PH_PAYLOAD;
                    end
                    else if (rx_byte != BYTE_CR)
                    begin
                        phase_next = PH_HUNT_CR;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (idx_reg == IDX_LAST)
                    begin
                        idx_next   = '0;
                        phase_next = PH_TRAIL_LF;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                PH_TRAIL_LF:
                begin
                    phase_next = (rx_byte == BYTE_LF) ? PH_TRAIL_CR : PH_HUNT_CR;
                end
                PH_TRAIL_CR:
                begin
                    phase_next = PH_HUNT_CR;
                end
                default:
                begin
                    phase_next = PH_HUNT_CR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT_CR;
            idx_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
    end

    // Cell row shifts on payload bytes; frame completes on trailer CR
    assign ctl.shift = accept && (phase_reg == PH_PAYLOAD);
    assign ctl.done  = accept && (phase_reg == PH_TRAIL_CR) && (rx_byte == BYTE_CR);

    // Only the trailer CR slot can load the result register
    assign at_trail_cr = (phase_reg == PH_TRAIL_CR);

endmodule

>>> hdl/pose_frame_deframer_top.sv
// Pose frame deframer.
// rx carries one received UART byte per transfer (valid/ready). The block
// hunts for 0x0D 0x0A, collects 24 payload bytes, then checks 0x0A 0x0D.
// A repeated 0x0D while waiting for the header 0x0A keeps waiting; any other
// mismatch drops back to the header hunt.
// res carries one transfer per good frame: six 32-bit words built
// little-endian from payload bytes 0-3, 4-7, ... 20-23 (raw float bits).
// Throughput: one byte per cycle, except where a waiting result holds rx;
// payload bytes march through a row of 24 byte cells, one step per byte.
// Latency: the result is valid the cycle after the trailer 0x0D transfer.
// The result sits in an output register; rx stays ready while it waits, so
// bytes keep flowing into the cell row meanwhile. A stalled result stops rx
// only once the next frame has reached its trailer 0x0D slot.
// Reset (rst_n, async, active low) returns to the header hunt with no result
// pending; payload cells are not cleared and need not be.
module pose_frame_deframer_top (
    input  logic       clk,
    input  logic       rst_n,
    pfd_byte_if.sink   rx,
    pfd_pose_if.source res
);
    import pfd_pkg::*;

    pfd_ctrl_t          ctl;
    logic               at_trail_cr;
    logic               accept;
    logic [BYTE_W-1:0]  cell_byte [PAYLOAD_LEN];
    logic               res_valid_reg, res_valid_next;
    logic [WORD_W-1:0]  word_reg [WORD_COUNT];

    // Hold rx only where a new frame could overwrite a waiting result
    assign rx.ready = !res_valid_reg || res.ready || !at_trail_cr;
    assign accept   = rx.valid && rx.ready;

    pfd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx.rx_byte),
        .ctl         (ctl),
        .at_trail_cr (at_trail_cr)
    );

    // Byte row: new byte enters the top cell, older bytes move down.
    // After 24 shifts cell k holds payload byte k.
    genvar k;
    generate
        for (k = 0; k < PAYLOAD_LEN; k++)
        begin : g_cell
            if (k == PAYLOAD_LEN - 1)
            begin : g_top
                pfd_byte_cell u_cell (
                    .clk      (clk),
                    .shift    (ctl.shift),
                    .byte_in  (rx.rx_byte),
                    .byte_out (cell_byte[k])
                );
            end
            else
            begin : g_mid
                pfd_byte_cell u_cell (
                    .clk      (clk),
                    .shift    (ctl.shift),
                    .byte_in  (cell_byte[k+1]),
                    .byte_out (cell_byte[k])
                );
            end
        end
    endgenerate

    // Result register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (ctl.done)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    genvar w;
    generate
        for (w = 0; w < WORD_COUNT; w++)
        begin : g_word
            always_ff @(posedge clk)
            begin
                if (ctl.done)
                begin
                    word_reg[w] <= {cell_byte[4*w+3], cell_byte[4*w+2],
                                    cell_byte[4*w+1], cell_byte[4*w]};
                end
            end
        end
    endgenerate

    assign res.valid         = res_valid_reg;
    assign res.yaw_bits      = word_reg[0];
    assign res.pitch_bits    = word_reg[1];
    assign res.roll_bits     = word_reg[2];
    assign res.pos_x_bits    = word_reg[3];
    assign res.pos_y_bits    = word_reg[4];
    assign res.yaw_rate_bits = word_reg[5];

endmodule

>>> test/pfd_checker.sv
`timescale 1ns / 100ps

// Watches both channels, keeps its own deframer state and compares each
// pose transfer against the oldest expected pose.
module pfd_checker (
    input  logic clk,
    input  logic rst_n,
    pfd_byte_if  rx,
    pfd_pose_if  res,
    output int   mismatches,
    output int   poses_pending,
    output int   poses_checked
);
    import pfd_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] yaw;
        logic [WORD_W-1:0] pitch;
        logic [WORD_W-1:0] roll;
        logic [WORD_W-1:0] pos_x;
        logic [WORD_W-1:0] pos_y;
        logic [WORD_W-1:0] yaw_rate;
    } pose_words_t;

    phase_t            deframe_phase = PH_HUNT_CR;
    int                slot = 0;
    logic [BYTE_W-1:0] payload_bytes [PAYLOAD_LEN];
    pose_words_t       expected_poses [$];
    pose_words_t       want;

    task automatic report(input string msg);
        $display("%0t ns MISMATCH %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_word(input string name, input logic [WORD_W-1:0] got,
                              input logic [WORD_W-1:0] exp_word);
        if (got !== exp_word)
            report($sformatf("%s: got %08h, expected %08h", name, got, exp_word));
    endtask

    // Little-endian word from four payload bytes
    function automatic logic [WORD_W-1:0] le_word(input int base);
        return {payload_bytes[base+3], payload_bytes[base+2],
                payload_bytes[base+1], payload_bytes[base]};
    endfunction

    // One accepted byte through the frame state machine
    task automatic take_byte(input logic [BYTE_W-1:0] b);
        pose_words_t p;
        case (deframe_phase)
            PH_HUNT_CR:
                deframe_phase = (b == BYTE_CR) ? PH_HEAD_LF : PH_HUNT_CR;
            PH_HEAD_LF:
                if (b == BYTE_LF)
                begin
                    slot = 0;
                    deframe_phase = PH_PAYLOAD;
                end
                else if (b != BYTE_CR)
                begin
                    deframe_phase = PH_HUNT_CR;
                end
            PH_PAYLOAD:
            begin
                payload_bytes[slot] = b;
                slot++;
                if (slot >= PAYLOAD_LEN)
                begin
                    slot = 0;
                    deframe_phase = PH_TRAIL_LF;
                end
            end
            PH_TRAIL_LF:
                deframe_phase = (b == BYTE_LF) ? PH_TRAIL_CR : PH_HUNT_CR;
            PH_TRAIL_CR:
            begin
                // mismatching byte is dropped, not taken as a header start
                if (b == BYTE_CR)
                begin
                    p.yaw      = le_word(0);
                    p.pitch    = le_word(4);
                    p.roll     = le_word(8);
                    p.pos_x    = le_word(12);
                    p.pos_y    = le_word(16);
                    p.yaw_rate = le_word(20);
                    expected_poses.push_back(p);
                end
                deframe_phase = PH_HUNT_CR;
            end
            default:
                deframe_phase = PH_HUNT_CR;
        endcase
    endtask

    // Result check first, then prediction from the byte taken at this edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deframe_phase = PH_HUNT_CR;
            slot = 0;
            expected_poses.delete();
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (expected_poses.size() == 0)
                begin
                    report($sformatf("unexpected pose transfer, yaw_bits %08h",
                                     res.yaw_bits));
                end
                else
                begin
                    want = expected_poses.pop_front();
                    check_word("yaw_bits", res.yaw_bits, want.yaw);
                    check_word("pitch_bits", res.pitch_bits, want.pitch);
                    check_word("roll_bits", res.roll_bits, want.roll);
                    check_word("pos_x_bits", res.pos_x_bits, want.pos_x);
                    check_word("pos_y_bits", res.pos_y_bits, want.pos_y);
                    check_word("yaw_rate_bits", res.yaw_rate_bits, want.yaw_rate);
                    poses_checked++;
                end
            end
            if (rx.valid && rx.ready)
                take_byte(rx.rx_byte);
        end
        poses_pending <= expected_poses.size();
    end

endmodule

>>> test/tb_pose_frame_deframer_top.sv
`timescale 1ns / 100ps

module tb_pose_frame_deframer_top;
    import pfd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_BYTES  = 440;

    typedef enum int {
        BREAK_NONE,
        BREAK_HEADER,
        BREAK_TRAIL_LF,
        BREAK_TRAIL_CR
    } frame_break_t;

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   bytes_sent;
    int   frames_sent;
    int   cycle_count;
    int   mismatches;
    int   poses_pending;
    int   poses_checked;

    pfd_byte_if rx_if ();
    pfd_pose_if res_if ();

    pose_frame_deframer_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .res   (res_if)
    );

    pfd_checker pose_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx            (rx_if),
        .res           (res_if),
        .mismatches    (mismatches),
        .poses_pending (poses_pending),
        .poses_checked (poses_checked)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Receiver stalls
    always @(posedge clk)
        res_if.ready <= ($urandom_range(99) >= stall_pct);

    // Run-time guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Payload byte biased toward the framing bytes and the extremes
    function automatic logic [BYTE_W-1:0] payload_byte();
        case ($urandom_range(7))
            0:       return BYTE_CR;
            1:       return BYTE_LF;
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    // Byte that breaks a frame: neither of the two given values
    function automatic logic [BYTE_W-1:0] wrong_byte(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] v;
        do
        begin
            case ($urandom_range(3))
                0:       v = BYTE_CR;
                1:       v = BYTE_LF;
                default: v = BYTE_W'($urandom_range(255));
            endcase
        end
        while (v == a || v == b);
        return v;
    endfunction

    // One byte transfer, with random sender idle cycles ahead of it
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Frame with optional repeated header CRs, optionally broken at one point
    task automatic send_frame(input int extra_crs, input frame_break_t brk);
        send_byte(BYTE_CR);
        repeat (extra_crs) send_byte(BYTE_CR);
        if (brk == BREAK_HEADER)
        begin
            send_byte(wrong_byte(BYTE_LF, BYTE_CR));
            return;
        end
        send_byte(BYTE_LF);
        repeat (PAYLOAD_LEN) send_byte(payload_byte());
        if (brk == BREAK_TRAIL_LF)
        begin
            send_byte(wrong_byte(BYTE_LF, BYTE_LF));
            return;
        end
        send_byte(BYTE_LF);
        if (brk == BREAK_TRAIL_CR)
        begin
            send_byte(wrong_byte(BYTE_CR, BYTE_CR));
            return;
        end
        send_byte(BYTE_CR);
        frames_sent++;
    endtask

    // Sender holds off until every expected pose has been taken
    task automatic wait_drained();
        rx_if.valid <= 1'b0;
        @(posedge clk);
        while (poses_pending != 0)
            @(posedge clk);
    endtask

    // Mostly good frames, some broken ones, some line noise
    task automatic random_traffic(input int n);
        int first;
        int pick;
        first = bytes_sent;
        while (bytes_sent - first < n)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_frame(($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0,
                           BREAK_NONE);
            else if (pick < 85)
                send_frame($urandom_range(1), frame_break_t'($urandom_range(1, 3)));
            else
                repeat ($urandom_range(1, 5)) send_byte(BYTE_W'($urandom_range(255)));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready  = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        bytes_sent    = 0;
        frames_sent   = 0;
        cycle_count   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: noise, repeated header CR, extreme and framing payload bytes
        send_byte(8'hFF);
        send_byte(BYTE_CR);
        send_byte(BYTE_CR);
        send_byte(BYTE_LF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(BYTE_CR);
        send_byte(BYTE_LF);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h01);
        send_byte(8'hFE);
        for (int k = 0; k < PAYLOAD_LEN - 8; k++)
            send_byte(BYTE_W'(8'h11 * k + 8'h3C));
        send_byte(BYTE_LF);
        send_byte(BYTE_CR);
        frames_sent++;
        wait_drained();

        // Random traffic under each idle/stall mix
        idle_pct = 0;  stall_pct = 0;
        random_traffic(PHASE_BYTES);
        wait_drained();
        idle_pct = 73; stall_pct = 0;
        random_traffic(PHASE_BYTES);
        wait_drained();
        idle_pct = 0;  stall_pct = 73;
        random_traffic(PHASE_BYTES);
        wait_drained();
        idle_pct = 31; stall_pct = 31;
        random_traffic(PHASE_BYTES);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d bytes with %0d good frames, plus broken frames and noise,",
                 bytes_sent, frames_sent);
        $display("under four idle/stall mixes; %0d poses checked, %0d mismatches",
                 poses_checked, mismatches);
        if (mismatches == 0 && poses_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
